@@ rtl/spq_pkg.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// Sorted priority queue package
// Command and status codes and the control word shared by the cell chain.
// ---------------------------------------------------------------------------
package spq_pkg;

   localparam logic CMD_PUSH = 1'b0;
   localparam logic CMD_POP  = 1'b1;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } spq_status_type;

   // one operation broadcast to every cell, already gated by full/empty
   typedef struct packed {
      logic push;
      logic pop;
   } spq_ctl_type;

endpackage
`default_nettype wire

@@ rtl/sorted_priority_queue.sv @@
`default_nettype none
// The result word is registered and is on the rsp_ ports in the cycle after
// start is accepted. Throughput: one command per cycle; every cell compares
// and shifts at once, so busy never rises.
// Reset (synchronous, active high) empties the queue and clears the strobe;
// the result receiver cannot stall, each result shows for one cycle only.
// ---------------------------------------------------------------------------
// Sorted priority queue
// Min-first queue kept sorted in a row of cells, with push and pop commands.
// ---------------------------------------------------------------------------
module sorted_priority_queue #(
   parameter int DEPTH     = 16,
   parameter int PRIO_BITS = 8,
   parameter int DATA_BITS = 32
) (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               start,
   output logic                              busy,
   input  wire                               req_cmd,
   input  wire  signed [DATA_BITS-1:0]       req_value,
   input  wire         [PRIO_BITS-1:0]       req_prio,
   output logic                              rsp_valid,
   output spq_pkg::spq_status_type           rsp_status,
   output logic signed [DATA_BITS-1:0]       rsp_popped_value,
   output logic signed [DATA_BITS-1:0]       rsp_head_value,
   output logic                              rsp_is_empty,
   output logic        [$clog2(DEPTH+1)-1:0] rsp_occupancy
);
   import spq_pkg::*;

   localparam int CNT_BITS = $clog2(DEPTH + 1);

   logic [CNT_BITS-1:0]  count_ff, count_in;
   logic                 valid_ff, valid_in;
   spq_status_type       status_ff, status_in;
   logic [DATA_BITS-1:0] popped_ff, popped_in;

   logic                 accept, full, empty;
   spq_ctl_type          ctl;

   logic                 ge    [DEPTH];
   logic [DATA_BITS-1:0] value [DEPTH];
   logic [PRIO_BITS-1:0] prio  [DEPTH];
   logic                 occ   [DEPTH];

   assign busy   = 1'b0;
   assign accept = start && !busy;
   assign full   = (count_ff == CNT_BITS'(DEPTH));
   assign empty  = (count_ff == '0);

   assign ctl.push = accept && (req_cmd == CMD_PUSH) && !full;
   assign ctl.pop  = accept && (req_cmd == CMD_POP) && !empty;

   genvar gi;
   generate
      for (gi = 0; gi < DEPTH; gi++) begin : g_cell
         assign occ[gi] = (count_ff > CNT_BITS'(gi));
         if (gi == 0) begin : g_head
            spq_cell #(
               .DATA_BITS (DATA_BITS),
               .PRIO_BITS (PRIO_BITS),
               .IS_HEAD   (1'b1)
            ) u_cell (
               .clock       (clock),
               .ctl         (ctl),
               .occupied    (occ[gi]),
               .new_value   (req_value),
               .new_prio    (req_prio),
               .left_ge     (1'b0),
               .left_value  (req_value),
               .left_prio   (req_prio),
               .right_value (value[(gi + 1) % DEPTH]),
               .right_prio  (prio[(gi + 1) % DEPTH]),
               .ge          (ge[gi]),
               .value       (value[gi]),
               .prio        (prio[gi])
            );
         end else if (gi == DEPTH - 1) begin : g_tail
            // last slot has no right neighbor: hold on pop
            spq_cell #(
               .DATA_BITS (DATA_BITS),
               .PRIO_BITS (PRIO_BITS),
               .IS_HEAD   (1'b0)
            ) u_cell (
               .clock       (clock),
               .ctl         (ctl),
               .occupied    (occ[gi]),
               .new_value   (req_value),
               .new_prio    (req_prio),
               .left_ge     (ge[gi - 1]),
               .left_value  (value[gi - 1]),
               .left_prio   (prio[gi - 1]),
               .right_value (value[gi]),
               .right_prio  (prio[gi]),
               .ge          (ge[gi]),
               .value       (value[gi]),
               .prio        (prio[gi])
            );
         end else begin : g_mid
            spq_cell #(
               .DATA_BITS (DATA_BITS),
               .PRIO_BITS (PRIO_BITS),
               .IS_HEAD   (1'b0)
            ) u_cell (
               .clock       (clock),
               .ctl         (ctl),
               .occupied    (occ[gi]),
               .new_value   (req_value),
               .new_prio    (req_prio),
               .left_ge     (ge[gi - 1]),
               .left_value  (value[gi - 1]),
               .left_prio   (prio[gi - 1]),
               .right_value (value[gi + 1]),
               .right_prio  (prio[gi + 1]),
               .ge          (ge[gi]),
               .value       (value[gi]),
               .prio        (prio[gi])
            );
         end
      end
   endgenerate

   always_comb begin
      count_in  = count_ff;
      status_in = ST_OK;
      popped_in = '0;
      valid_in  = accept;
      if (ctl.push) begin
         count_in = count_ff + 1'b1;
      end else if (ctl.pop) begin
         count_in  = count_ff - 1'b1;
         popped_in = value[0];
      end else if (accept) begin
         status_in = (req_cmd == CMD_PUSH) ? ST_FULL : ST_EMPTY;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         valid_ff <= valid_in;
      end
      status_ff <= status_in;
      popped_ff <= popped_in;
   end

   // head, emptiness and count come straight from the updated chain
   assign rsp_valid        = valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_popped_value = popped_ff;
   assign rsp_head_value   = empty ? '0 : value[0];
   assign rsp_is_empty     = empty;
   assign rsp_occupancy    = count_ff;

`ifndef ASSERT_OFF
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_BITS'(DEPTH))
      else $error("occupancy beyond depth");

   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> rsp_valid)
      else $error("accepted command gave no result word");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_FULL |-> rsp_occupancy == CNT_BITS'(DEPTH))
      else $error("full status on a queue that is not full");

   a_push_count: assert property (@(posedge clock) disable iff (reset)
      ctl.push |=> count_ff == $past(count_ff) + 1'b1)
      else $error("push did not grow the queue");
`endif

endmodule
`default_nettype wire

@@ rtl/spq_cell.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// Sorted priority queue cell
// Holds one slot. On push it keeps, takes the new entry or takes its left
// neighbor's entry; on pop it takes its right neighbor's entry.
// ---------------------------------------------------------------------------
module spq_cell #(
   parameter int DATA_BITS = 32,
   parameter int PRIO_BITS = 8,
   parameter bit IS_HEAD   = 1'b0
) (
   input  wire                      clock,
   input  spq_pkg::spq_ctl_type     ctl,
   input  wire                      occupied,
   input  wire  [DATA_BITS-1:0]     new_value,
   input  wire  [PRIO_BITS-1:0]     new_prio,
   input  wire                      left_ge,
   input  wire  [DATA_BITS-1:0]     left_value,
   input  wire  [PRIO_BITS-1:0]     left_prio,
   input  wire  [DATA_BITS-1:0]     right_value,
   input  wire  [PRIO_BITS-1:0]     right_prio,
   output logic                     ge,
   output logic [DATA_BITS-1:0]     value,
   output logic [PRIO_BITS-1:0]     prio
);
   import spq_pkg::*;

   logic [DATA_BITS-1:0] value_ff, value_in;
   logic [PRIO_BITS-1:0] prio_ff, prio_in;

   // head yields only to a strictly smaller number, the rest to not-greater
   always_comb begin
      if (!occupied) begin
         ge = 1'b1;
      end else if (IS_HEAD) begin
         ge = (prio_ff > new_prio);
      end else begin
         ge = (prio_ff >= new_prio);
      end
   end

   always_comb begin
      value_in = value_ff;
      prio_in  = prio_ff;
      if (ctl.push && ge) begin
         if (left_ge) begin
            value_in = left_value;
            prio_in  = left_prio;
         end else begin
            value_in = new_value;
            prio_in  = new_prio;
         end
      end else if (ctl.pop) begin
         value_in = right_value;
         prio_in  = right_prio;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      prio_ff  <= prio_in;
   end

   assign value = value_ff;
   assign prio  = prio_ff;

endmodule
`default_nettype wire

@@ verif/tb_sorted_priority_queue.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Sorted priority queue testbench
// Feeds push and pop commands through a start/busy driver, and predicts
// every response word with a behavioral min-first queue. Each strobed
// response is checked field by field in order.
// ---------------------------------------------------------------------------
module tb_sorted_priority_queue;
   import spq_pkg::*;

   localparam int DEPTH       = 16;
   localparam int RANDOM_OPS  = 1400;
   localparam int CALM_TAIL   = 150;
   localparam int STALL_LIMIT = 1000;
   localparam int REPORT_MAX  = 10;

   typedef struct {
      logic               cmd;
      logic signed [31:0] value;
      logic        [7:0]  prio;
   } queue_op_type;

   typedef struct {
      spq_status_type     status;
      logic signed [31:0] popped_value;
      logic signed [31:0] head_value;
      logic               is_empty;
      logic        [4:0]  occupancy;
   } queue_rsp_type;

   logic               clock     = 1'b0;
   logic               reset     = 1'b1;
   logic               start     = 1'b0;
   logic               req_cmd   = CMD_PUSH;
   logic signed [31:0] req_value = '0;
   logic        [7:0]  req_prio  = '0;
   logic               busy;
   logic               rsp_valid;
   spq_status_type     rsp_status;
   logic signed [31:0] rsp_popped_value;
   logic signed [31:0] rsp_head_value;
   logic               rsp_is_empty;
   logic        [4:0]  rsp_occupancy;

   queue_op_type  pending_ops[$];
   queue_rsp_type expected_responses[$];
   int         total_ops    = 0;
   int         ops_accepted = 0;
   int         fail_count   = 0;
   int         stall_cycles = 0;
   int         idle_left    = 0;
   logic       op_taken     = 1'b0;

   // behavioral copy of the sorted entry file
   logic signed [31:0] model_value[DEPTH];
   logic        [7:0]  model_prio[DEPTH];
   int                 model_count = 0;

   sorted_priority_queue #(
      .DEPTH(DEPTH),
      .PRIO_BITS(8),
      .DATA_BITS(32)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_cmd(req_cmd),
      .req_value(req_value),
      .req_prio(req_prio),
      .rsp_valid(rsp_valid),
      .rsp_status(rsp_status),
      .rsp_popped_value(rsp_popped_value),
      .rsp_head_value(rsp_head_value),
      .rsp_is_empty(rsp_is_empty),
      .rsp_occupancy(rsp_occupancy)
   );

   always #2 clock = ~clock;

   function automatic queue_rsp_type next_queue_response(logic cmd,
                                                         logic signed [31:0] value,
                                                         logic [7:0] prio);
      queue_rsp_type rsp;
      int pos;
      int k;
      rsp.status = ST_OK;
      rsp.popped_value = '0;
      if (cmd == CMD_PUSH) begin
         if (model_count >= DEPTH) begin
            rsp.status = ST_FULL;
         end else begin
            // ties with the head land behind it and behind lower numbers
            if (model_count == 0 || model_prio[0] > prio) begin
               pos = 0;
            end else begin
               pos = 1;
               while (pos < model_count && model_prio[pos] < prio) pos++;
            end
            for (k = model_count; k > pos; k--) begin
               model_value[k] = model_value[k-1];
               model_prio[k] = model_prio[k-1];
            end
            model_value[pos] = value;
            model_prio[pos] = prio;
            model_count++;
         end
      end else begin
         if (model_count == 0) begin
            rsp.status = ST_EMPTY;
         end else begin
            rsp.popped_value = model_value[0];
            for (k = 1; k < model_count; k++) begin
               model_value[k-1] = model_value[k];
               model_prio[k-1] = model_prio[k];
            end
            model_count--;
         end
      end
      rsp.head_value = (model_count > 0) ? model_value[0] : '0;
      rsp.is_empty = (model_count == 0);
      rsp.occupancy = model_count[4:0];
      return rsp;
   endfunction

   task automatic add_op(logic cmd, logic signed [31:0] value, logic [7:0] prio);
      queue_op_type op;
      op.cmd = cmd;
      op.value = value;
      op.prio = prio;
      pending_ops.push_back(op);
   endtask

   initial begin
      int i;
      int push_pct;
      logic               cmd;
      logic signed [31:0] value;
      logic        [7:0]  prio;
      push_pct = 50;

      add_op(CMD_POP, 32'sd0, 8'd0);
      add_op(CMD_PUSH, 32'sh7fffffff, 8'd128);
      add_op(CMD_PUSH, 32'sh80000000, 8'd128);
      add_op(CMD_PUSH, -32'sd1, 8'd0);
      add_op(CMD_PUSH, 32'sd0, 8'd255);
      add_op(CMD_PUSH, 32'sh55555555, 8'd128);
      for (i = 0; i < 11; i++) add_op(CMD_PUSH, 32'shaaaaaaaa ^ i, 8'(i * 23));
      add_op(CMD_PUSH, 32'sd1, 8'd7);
      add_op(CMD_POP, 32'sh7fffffff, 8'd255);
      add_op(CMD_POP, 32'sd0, 8'd0);

      // swing between filling and draining so full and empty are both hit
      for (i = 0; i < RANDOM_OPS; i++) begin
         if (i % 40 == 0) begin
            case ($urandom_range(0, 2))
               0: push_pct = 15;
               1: push_pct = 50;
               default: push_pct = 90;
            endcase
         end
         cmd = ($urandom_range(0, 99) < push_pct) ? CMD_PUSH : CMD_POP;
         case ($urandom_range(0, 7))
            0: value = 32'sh7fffffff;
            1: value = 32'sh80000000;
            default: value = $urandom;
         endcase
         case ($urandom_range(0, 3))
            0: prio = 8'($urandom_range(0, 255));
            1: prio = 8'($urandom_range(0, 3));
            2: prio = $urandom_range(0, 1) ? 8'd255 : 8'd0;
            default: prio = 8'($urandom_range(120, 130));
         endcase
         add_op(cmd, value, prio);
      end
      total_ops = pending_ops.size();

      repeat (5) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      while (ops_accepted != total_ops || expected_responses.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      if (fail_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // driver: hold a word until taken, then advance or idle for a burst
   always @(negedge clock) begin : drive_ops
      queue_op_type op;
      int idle_pct;
      case ((pending_ops.size() / 200) % 3)
         0: idle_pct = 0;
         1: idle_pct = 10;
         default: idle_pct = 30;
      endcase
      if (reset) begin
         start <= 1'b0;
      end else if (!start || op_taken) begin
         if (idle_left > 0) begin
            idle_left = idle_left - 1;
            start <= 1'b0;
         end else if (pending_ops.size() == 0) begin
            start <= 1'b0;
         end else if (pending_ops.size() > CALM_TAIL && $urandom_range(0, 99) < idle_pct) begin
            idle_left = $urandom_range(0, 4);
            start <= 1'b0;
         end else begin
            op = pending_ops.pop_front();
            start <= 1'b1;
            req_cmd <= op.cmd;
            req_value <= op.value;
            req_prio <= op.prio;
         end
      end
   end

   // monitor: predict on acceptance, then check any strobed response
   always @(posedge clock) begin : check_rsp
      queue_rsp_type want;
      if (reset) begin
         op_taken <= 1'b0;
      end else begin
         if (start && !busy) begin
            expected_responses.push_back(next_queue_response(req_cmd, req_value, req_prio));
            ops_accepted++;
         end
         op_taken <= start && !busy;
         if (rsp_valid) begin
            if (expected_responses.size() == 0) begin
               fail_count++;
               if (fail_count <= REPORT_MAX)
                  $display("%0t: unexpected response status=%0d popped=%0d head=%0d occ=%0d",
                           $time, rsp_status, rsp_popped_value, rsp_head_value, rsp_occupancy);
            end else begin
               want = expected_responses.pop_front();
               if (rsp_status !== want.status || rsp_popped_value !== want.popped_value ||
                   rsp_head_value !== want.head_value || rsp_is_empty !== want.is_empty ||
                   rsp_occupancy !== want.occupancy) begin
                  fail_count++;
                  if (fail_count <= REPORT_MAX) begin
                     $display("%0t: expected status=%0d popped=%0d head=%0d empty=%0b occ=%0d",
                              $time, want.status, want.popped_value, want.head_value,
                              want.is_empty, want.occupancy);
                     $display("%0t: actual   status=%0d popped=%0d head=%0d empty=%0b occ=%0d",
                              $time, rsp_status, rsp_popped_value, rsp_head_value,
                              rsp_is_empty, rsp_occupancy);
                  end
               end
            end
         end
      end
   end

   // watchdog: drop the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT - 1) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

endmodule

@@ sorted_priority_queue.f @@
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/sorted_priority_queue.sv
verif/tb_sorted_priority_queue.sv
